>>> hdl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS = 16;          // fraction bits of matrix entries
  localparam int IN_FRAC   = 16;          // fraction bits of eye/target
  localparam int CRD_W     = 32;          // coordinate / matrix entry width
  localparam int UP_W      = 18;          // up vector register width

  // normalized basis component: magnitude up to 1.0
  localparam int NW        = FRAC_BITS + 2;
  localparam int QW        = FRAC_BITS + 1;

  // normalizer input width: covers eye-target and both cross products
  localparam int VW_A      = CRD_W + 1;
  localparam int VW_B      = UP_W + NW + 1;
  localparam int VW_C      = 2 * NW + 1;
  localparam int VW_AB     = (VW_A > VW_B) ? VW_A : VW_B;
  localparam int VW        = (VW_AB > VW_C) ? VW_AB : VW_C;

  localparam int SC_W      = 30;          // scaled magnitude, MSB lands at bit 29
  localparam int SQ_W      = 2 * SC_W + 2;
  localparam int RT_W      = SQ_W + 1;
  localparam int SQRT_N    = SQ_W / 2;
  localparam int LEN_W     = SC_W + 1;
  localparam int DW        = SC_W + FRAC_BITS + 1;
  localparam int PW        = $clog2(VW);

  localparam int PA_W      = UP_W + NW;   // up x forward products
  localparam int PB_W      = 2 * NW;      // forward x right products
  localparam int DP_W      = NW + CRD_W;  // basis . eye products
  localparam int DS_W      = DP_W + 2;

  localparam logic [CRD_W-1:0] FX_ONE = CRD_W'(1) << FRAC_BITS;

  localparam logic [UP_W-1:0] UP_X_RST = UP_W'(0);
  localparam logic [UP_W-1:0] UP_Y_RST = UP_W'(65536);
  localparam logic [UP_W-1:0] UP_Z_RST = UP_W'(0);

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_X = 2'd0,
    CFG_UP_Y = 2'd1,
    CFG_UP_Z = 2'd2
  } cfg_reg_t;

  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic [2:0][VW-1:0] vin_t;
  typedef logic [2:0][NW-1:0] nvec_t;
  typedef logic [2:0][SC_W-1:0] scv_t;

  typedef struct packed {
    logic [2:0][CRD_W-1:0] eye;
    nvec_t                 fwd;
    nvec_t                 rgt;
    logic                  degen;
  } side_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] eye_x;
    logic signed [CRD_W-1:0] eye_y;
    logic signed [CRD_W-1:0] eye_z;
    logic signed [CRD_W-1:0] target_x;
    logic signed [CRD_W-1:0] target_y;
    logic signed [CRD_W-1:0] target_z;
  } lav_in_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [CRD_W-1:0] col0;
    logic signed [CRD_W-1:0] col1;
    logic signed [CRD_W-1:0] col2;
    logic signed [CRD_W-1:0] col3;
    logic                    last_row;
    logic                    degenerate;
  } lav_out_t;

endpackage

>>> hdl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds a look-at view matrix from an eye and a target point, one row per
// output transaction.
// ----------------------------------------------------------------------------
// Each accepted eye/target transaction produces four row transactions, rows 0
// to 3, with last_row set on row 3. The datapath is a fully pipelined chain of
// three normalizers (forward, right, up') with cross products between them and
// the translation dot products after the last; a new transaction can enter
// every cycle while the pipeline moves. The output row register hands out one
// row per cycle while out_stall is low and takes the next matrix when empty or
// as row 3 of the current one is handed out; in_stall rises only when the
// pipeline's last stage holds a matrix that the row register cannot yet take.
// Up-vector registers are written through the cfg port (always ready) and must
// change only while idle.
// ----------------------------------------------------------------------------
module look_at_view_matrix
  import lav_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lav_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lav_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [UP_W-1:0]      cfg_data
);

  logic en;

  // configuration registers
  logic [UP_W-1:0] up_x_r, up_y_r, up_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= UP_X_RST;
      up_y_r <= UP_Y_RST;
      up_z_r <= UP_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UP_X: up_x_r <= cfg_data;
        CFG_UP_Y: up_y_r <= cfg_data;
        CFG_UP_Z: up_z_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // T1: capture eye, forward direction = eye - target
  logic                  t1_v_r;
  logic [2:0][CRD_W-1:0] t1_eye_r;
  logic [2:0][CRD_W:0]   t1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_eye_r[0] <= in_data.eye_x;
      t1_eye_r[1] <= in_data.eye_y;
      t1_eye_r[2] <= in_data.eye_z;
      t1_d_r[0]   <= {in_data.eye_x[CRD_W-1], in_data.eye_x}
                   - {in_data.target_x[CRD_W-1], in_data.target_x};
      t1_d_r[1]   <= {in_data.eye_y[CRD_W-1], in_data.eye_y}
                   - {in_data.target_y[CRD_W-1], in_data.target_y};
      t1_d_r[2]   <= {in_data.eye_z[CRD_W-1], in_data.eye_z}
                   - {in_data.target_z[CRD_W-1], in_data.target_z};
    end
  end

  vin_t  n1_vec;
  side_t n1_side;
  logic  n1_v;
  nvec_t n1_out;
  logic  n1_ok;
  side_t n1_oside;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_vec[i] = VW'($signed(t1_d_r[i]));
    end
    n1_side       = '0;
    n1_side.eye   = t1_eye_r;
  end

  lav_norm u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t1_v_r),
    .in_vec    (n1_vec),
    .in_side   (n1_side),
    .out_valid (n1_v),
    .out_vec   (n1_out),
    .out_ok    (n1_ok),
    .out_side  (n1_oside)
  );

  // T2/T3: up x forward
  logic                   t2_v_r;
  logic signed [PA_W-1:0] t2_pa_r [3];
  logic signed [PA_W-1:0] t2_pb_r [3];
  side_t                  t2_side_r;
  logic                   t3_v_r;
  vin_t                   t3_vec_r;
  side_t                  t3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
    end else if (en) begin
      t2_v_r <= n1_v;
      t3_v_r <= t2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_pa_r[0] <= $signed(up_y_r) * $signed(n1_out[2]);
      t2_pb_r[0] <= $signed(up_z_r) * $signed(n1_out[1]);
      t2_pa_r[1] <= $signed(up_z_r) * $signed(n1_out[0]);
      t2_pb_r[1] <= $signed(up_x_r) * $signed(n1_out[2]);
      t2_pa_r[2] <= $signed(up_x_r) * $signed(n1_out[1]);
      t2_pb_r[2] <= $signed(up_y_r) * $signed(n1_out[0]);
      t2_side_r.eye   <= n1_oside.eye;
      t2_side_r.fwd   <= n1_out;
      t2_side_r.rgt   <= n1_oside.rgt;
      t2_side_r.degen <= n1_oside.degen || !n1_ok;
      for (int i = 0; i < 3; i++) begin
        t3_vec_r[i] <= VW'(t2_pa_r[i]) - VW'(t2_pb_r[i]);
      end
      t3_side_r <= t2_side_r;
    end
  end

  logic  n2_v;
  nvec_t n2_out;
  logic  n2_ok;
  side_t n2_oside;

  lav_norm u_norm_rgt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t3_v_r),
    .in_vec    (t3_vec_r),
    .in_side   (t3_side_r),
    .out_valid (n2_v),
    .out_vec   (n2_out),
    .out_ok    (n2_ok),
    .out_side  (n2_oside)
  );

  // T4/T5: forward x right
  logic                   t4_v_r;
  logic signed [PB_W-1:0] t4_pa_r [3];
  logic signed [PB_W-1:0] t4_pb_r [3];
  side_t                  t4_side_r;
  logic                   t5_v_r;
  vin_t                   t5_vec_r;
  side_t                  t5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t4_v_r <= 1'b0;
      t5_v_r <= 1'b0;
    end else if (en) begin
      t4_v_r <= n2_v;
      t5_v_r <= t4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_pa_r[0] <= $signed(n2_oside.fwd[1]) * $signed(n2_out[2]);
      t4_pb_r[0] <= $signed(n2_oside.fwd[2]) * $signed(n2_out[1]);
      t4_pa_r[1] <= $signed(n2_oside.fwd[2]) * $signed(n2_out[0]);
      t4_pb_r[1] <= $signed(n2_oside.fwd[0]) * $signed(n2_out[2]);
      t4_pa_r[2] <= $signed(n2_oside.fwd[0]) * $signed(n2_out[1]);
      t4_pb_r[2] <= $signed(n2_oside.fwd[1]) * $signed(n2_out[0]);
      t4_side_r.eye   <= n2_oside.eye;
      t4_side_r.fwd   <= n2_oside.fwd;
      t4_side_r.rgt   <= n2_out;
      t4_side_r.degen <= n2_oside.degen || !n2_ok;
      for (int i = 0; i < 3; i++) begin
        t5_vec_r[i] <= VW'(t4_pa_r[i]) - VW'(t4_pb_r[i]);
      end
      t5_side_r <= t4_side_r;
    end
  end

  logic  n3_v;
  nvec_t n3_out;
  logic  n3_ok;
  side_t n3_oside;

  lav_norm u_norm_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t5_v_r),
    .in_vec    (t5_vec_r),
    .in_side   (t5_side_r),
    .out_valid (n3_v),
    .out_vec   (n3_out),
    .out_ok    (n3_ok),
    .out_side  (n3_oside)
  );

  // T6..T8: translation = -(basis . eye), rounded and saturated
  function automatic logic [CRD_W-1:0] neg_round_sat(input logic signed [DS_W-1:0] s);
    logic [DS_W-1:0] mag;
    logic [DS_W-1:0] r;
    mag = s[DS_W-1] ? (DS_W'(0) - DS_W'(s)) : DS_W'(s);
    r   = (mag + (DS_W'(1) << (IN_FRAC - 1))) >> IN_FRAC;
    if (!s[DS_W-1] && (s != '0)) begin
      if (r > DS_W'(64'd2147483648)) begin
        neg_round_sat = 32'h8000_0000;
      end else begin
        neg_round_sat = CRD_W'(DS_W'(0) - r);
      end
    end else if (r > DS_W'(64'd2147483647)) begin
      neg_round_sat = 32'h7fff_ffff;
    end else begin
      neg_round_sat = r[CRD_W-1:0];
    end
  endfunction

  logic                   t6_v_r;
  logic signed [DP_W-1:0] t6_p_r [3][3];   // [basis][component]
  nvec_t                  t6_rgt_r, t6_upn_r, t6_fwd_r;
  logic                   t6_degen_r;
  logic                   t7_v_r;
  logic signed [DS_W-1:0] t7_s_r [3];
  nvec_t                  t7_rgt_r, t7_upn_r, t7_fwd_r;
  logic                   t7_degen_r;
  logic                   t8_v_r;
  logic [2:0][CRD_W-1:0]  t8_tr_r;
  nvec_t                  t8_rgt_r, t8_upn_r, t8_fwd_r;
  logic                   t8_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t6_v_r <= 1'b0;
      t7_v_r <= 1'b0;
      t8_v_r <= 1'b0;
    end else if (en) begin
      t6_v_r <= n3_v;
      t7_v_r <= t6_v_r;
      t8_v_r <= t7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        t6_p_r[0][c] <= $signed(n3_oside.rgt[c]) * $signed(n3_oside.eye[c]);
        t6_p_r[1][c] <= $signed(n3_out[c]) * $signed(n3_oside.eye[c]);
        t6_p_r[2][c] <= $signed(n3_oside.fwd[c]) * $signed(n3_oside.eye[c]);
      end
      t6_rgt_r   <= n3_oside.rgt;
      t6_upn_r   <= n3_out;
      t6_fwd_r   <= n3_oside.fwd;
      t6_degen_r <= n3_oside.degen || !n3_ok;

      for (int b = 0; b < 3; b++) begin
        t7_s_r[b] <= DS_W'(t6_p_r[b][0]) + DS_W'(t6_p_r[b][1]) + DS_W'(t6_p_r[b][2]);
      end
      t7_rgt_r   <= t6_rgt_r;
      t7_upn_r   <= t6_upn_r;
      t7_fwd_r   <= t6_fwd_r;
      t7_degen_r <= t6_degen_r;

      for (int b = 0; b < 3; b++) begin
        t8_tr_r[b] <= neg_round_sat(t7_s_r[b]);
      end
      t8_rgt_r   <= t7_rgt_r;
      t8_upn_r   <= t7_upn_r;
      t8_fwd_r   <= t7_fwd_r;
      t8_degen_r <= t7_degen_r;
    end
  end

  // output row register: holds one matrix, hands out a row per transaction
  logic                  busy_r;
  logic [1:0]            row_r;
  nvec_t                 mx_rgt_r, mx_upn_r, mx_fwd_r;
  logic [2:0][CRD_W-1:0] mx_tr_r;
  logic                  mx_degen_r;
  logic                  out_done;
  logic [3:0][CRD_W-1:0] cols;

  assign out_done = busy_r && !out_stall && (row_r == ROW_LAST);
  assign en       = !t8_v_r || !busy_r || out_done;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else if (en && t8_v_r) begin
      busy_r <= 1'b1;
      row_r  <= '0;
    end else if (busy_r && !out_stall) begin
      busy_r <= (row_r != ROW_LAST);
      row_r  <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && t8_v_r) begin
      mx_rgt_r   <= t8_rgt_r;
      mx_upn_r   <= t8_upn_r;
      mx_fwd_r   <= t8_fwd_r;
      mx_tr_r    <= t8_tr_r;
      mx_degen_r <= t8_degen_r;
    end
  end

  always_comb begin
    cols = '0;
    if (mx_degen_r) begin
      cols[row_r] = FX_ONE;
    end else if (row_r == ROW_LAST) begin
      cols[0] = mx_tr_r[0];
      cols[1] = mx_tr_r[1];
      cols[2] = mx_tr_r[2];
      cols[3] = FX_ONE;
    end else begin
      cols[0] = CRD_W'($signed(mx_rgt_r[row_r]));
      cols[1] = CRD_W'($signed(mx_upn_r[row_r]));
      cols[2] = CRD_W'($signed(mx_fwd_r[row_r]));
    end
  end

  assign out_valid           = busy_r;
  assign out_data.row_index  = row_r;
  assign out_data.col0       = cols[0];
  assign out_data.col1       = cols[1];
  assign out_data.col2       = cols[2];
  assign out_data.col3       = cols[3];
  assign out_data.last_row   = (row_r == ROW_LAST);
  assign out_data.degenerate = mx_degen_r;

endmodule

>>> hdl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale, sum of squares, bit-per-stage square
// root, bit-per-stage divide. Carries a sideband alongside each vector.
// ----------------------------------------------------------------------------
module lav_norm
  import lav_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  vin_t  in_vec,
  input  side_t in_side,
  output logic  out_valid,
  output nvec_t out_vec,
  output logic  out_ok,
  output side_t out_side
);

  typedef struct packed {
    scv_t       sc;
    logic [2:0] neg;
    logic       zero;
    side_t      side;
  } car_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [2:0]       neg;
    logic             zero;
    side_t            side;
  } div_t;

  // stage A: magnitudes
  logic [2:0][VW-1:0] mag_c;
  logic               a_vld_r;
  logic [2:0][VW-1:0] a_mag_r;
  logic [2:0]         a_neg_r;
  logic [VW-1:0]      a_or_r;
  side_t              a_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][VW-1] ? (VW'(0) - in_vec[i]) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= mag_c;
      for (int i = 0; i < 3; i++) begin
        a_neg_r[i] <= in_vec[i][VW-1];
      end
      // leading one of the OR equals that of the largest magnitude
      a_or_r   <= mag_c[0] | mag_c[1] | mag_c[2];
      a_side_r <= in_side;
    end
  end

  // stage B: leading one position
  logic [PW-1:0]      b_pos_nxt;
  logic               b_vld_r;
  logic [2:0][VW-1:0] b_mag_r;
  logic [2:0]         b_neg_r;
  logic [PW-1:0]      b_pos_r;
  logic               b_zero_r;
  side_t              b_side_r;

  always_comb begin
    b_pos_nxt = '0;
    for (int i = 0; i < VW; i++) begin
      if (a_or_r[i]) b_pos_nxt = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_pos_r  <= b_pos_nxt;
      b_zero_r <= (a_or_r == '0);
      b_side_r <= a_side_r;
    end
  end

  // stage C: move the top bit to bit SC_W-1 (right shifts truncate)
  logic c_vld_r;
  car_t c_car_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_car_r.sc[i] <= SC_W'(({{(SC_W-1){1'b0}}, b_mag_r[i]} << (SC_W - 1)) >> b_pos_r);
      end
      c_car_r.neg  <= b_neg_r;
      c_car_r.zero <= b_zero_r;
      c_car_r.side <= b_side_r;
    end
  end

  // stage D: squares
  logic                   d_vld_r;
  logic [2:0][2*SC_W-1:0] d_sq_r;
  car_t                   d_car_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= (2*SC_W)'(c_car_r.sc[i]) * (2*SC_W)'(c_car_r.sc[i]);
      end
      d_car_r <= c_car_r;
    end
  end

  // stage E and square root stages
  logic [SQ_W-1:0] sq_x_r [0:SQRT_N];
  logic [RT_W-1:0] sq_r_r [0:SQRT_N];
  car_t            sq_c_r [0:SQRT_N];
  logic            sq_v_r [0:SQRT_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0] <= SQ_W'(d_sq_r[0]) + SQ_W'(d_sq_r[1]) + SQ_W'(d_sq_r[2]);
      sq_r_r[0] <= '0;
      sq_c_r[0] <= d_car_r;
    end
  end

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam logic [RT_W-1:0] BIT = RT_W'(1) << (SQ_W - 2 - 2 * k);
    logic [RT_W-1:0] trial;

    assign trial = sq_r_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c_r[k+1] <= sq_c_r[k];
        if (RT_W'(sq_x_r[k]) >= trial) begin
          sq_x_r[k+1] <= SQ_W'(RT_W'(sq_x_r[k]) - trial);
          sq_r_r[k+1] <= (sq_r_r[k] >> 1) + BIT;
        end else begin
          sq_x_r[k+1] <= sq_x_r[k];
          sq_r_r[k+1] <= sq_r_r[k] >> 1;
        end
      end
    end
  end

  // stage F and divide stages: q = (sc * 2^F + len/2) / len
  logic [LEN_W-1:0]   len_c;
  logic [2:0][DW-1:0] dv_rem_r [0:QW];
  logic [2:0][QW-1:0] dv_q_r   [0:QW];
  div_t               dv_c_r   [0:QW];
  logic               dv_v_r   [0:QW];

  assign len_c = sq_r_r[SQRT_N][LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQRT_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= (DW'(sq_c_r[SQRT_N].sc[i]) << FRAC_BITS) + DW'(len_c >> 1);
      end
      dv_q_r[0]      <= '0;
      dv_c_r[0].len  <= len_c;
      dv_c_r[0].neg  <= sq_c_r[SQRT_N].neg;
      dv_c_r[0].zero <= sq_c_r[SQRT_N].zero;
      dv_c_r[0].side <= sq_c_r[SQRT_N].side;
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int J = QW - 1 - t;
    logic [DW-1:0] dvs;

    assign dvs = DW'(dv_c_r[t].len) << J;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[t+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[t+1] <= dv_v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c_r[t+1] <= dv_c_r[t];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_r[t][i] >= dvs) begin
            dv_rem_r[t+1][i] <= dv_rem_r[t][i] - dvs;
            dv_q_r[t+1][i]   <= dv_q_r[t][i] | (QW'(1) << J);
          end else begin
            dv_rem_r[t+1][i] <= dv_rem_r[t][i];
            dv_q_r[t+1][i]   <= dv_q_r[t][i];
          end
        end
      end
    end
  end

  // stage G: signs, zero vector
  logic  g_vld_r;
  nvec_t g_vec_r;
  logic  g_ok_r;
  side_t g_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_c_r[QW].zero) begin
          g_vec_r[i] <= '0;
        end else if (dv_c_r[QW].neg[i]) begin
          g_vec_r[i] <= NW'(0) - NW'(dv_q_r[QW][i]);
        end else begin
          g_vec_r[i] <= NW'(dv_q_r[QW][i]);
        end
      end
      g_ok_r   <= !dv_c_r[QW].zero;
      g_side_r <= dv_c_r[QW].side;
    end
  end

  assign out_valid = g_vld_r;
  assign out_vec   = g_vec_r;
  assign out_ok    = g_ok_r;
  assign out_side  = g_side_r;

endmodule

>>> hdl/lav_check.sv
// ----------------------------------------------------------------------------
// lav_check
// Port-level checks on the row output sequence of look_at_view_matrix.
// ----------------------------------------------------------------------------
module lav_check
  import lav_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input lav_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.row_index != ROW_LAST)
    |=> out_valid && (out_data.row_index == $past(out_data.row_index) + 2'd1))
    else $error("row sequence broken");

  a_degen_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.row_index != ROW_LAST)
    |=> out_data.degenerate == $past(out_data.degenerate))
    else $error("degenerate flag changed inside a matrix");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_row == (out_data.row_index == ROW_LAST))
    else $error("last_row does not match row 3");

  a_degen_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate
    |-> out_data.col3 == ((out_data.row_index == ROW_LAST) ? FX_ONE : 32'd0))
    else $error("degenerate matrix not identity");

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);
